// ----- rtl/core/izi_pkg.sv -----
// Shared types, codes and defaults of the 2x bilinear zoom.
package izi_pkg;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;

  localparam int DIM_W   = 11;
  localparam int COORD_W = 11;
  localparam int PIX_W   = 8;
  localparam int ADDR_W  = 3;
  localparam int DATA_W  = 32;

  localparam logic [DIM_W-1:0] DIM_RESET = 11'd1024;

  // Register select, taken from the word address bit of paddr.
  localparam logic REG_IMAGE_WIDTH  = 1'b0;
  localparam logic REG_IMAGE_HEIGHT = 1'b1;

  // Kinds of result, in emission order.
  localparam logic [1:0] KIND_DIAG  = 2'd0;
  localparam logic [1:0] KIND_VERT  = 2'd1;
  localparam logic [1:0] KIND_HORIZ = 2'd2;
  localparam logic [1:0] KIND_COPY  = 2'd3;

  localparam int QUEUE_DEPTH = 2;

  // One classified input pixel with all of its candidate results worked out.
  typedef struct packed {
    logic [COORD_W-1:0] row2;
    logic [COORD_W-1:0] col2;
    logic [PIX_W-1:0]   diag;
    logic [PIX_W-1:0]   vert;
    logic [PIX_W-1:0]   horiz;
    logic [PIX_W-1:0]   copy;
    logic               has_up;
    logic               has_left;
  } izi_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } izi_qstat_t;

endpackage

// ----- rtl/core/izi_front.sv -----
// Front part: accepts pixels, tracks position, reads the line store and forms the means.
module izi_front import izi_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [PIX_W-1:0] in_pixel,
  input  logic [DIM_W-1:0] image_width,
  input  logic [DIM_W-1:0] image_height,
  input  izi_qstat_t       q_stat,
  output logic             push,
  output izi_item_t        push_item
);

  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int RW   = $clog2(MAX_HEIGHT);
  localparam int CMPW = ((CW > DIM_W) ? CW : DIM_W) + 1;
  localparam int RMPW = ((RW > DIM_W) ? RW : DIM_W) + 1;

  logic [PIX_W-1:0] line_mem [MAX_WIDTH];
  logic [PIX_W-1:0] up_r;
  logic [PIX_W-1:0] upper_left_r;
  logic [PIX_W-1:0] left_r;
  logic [CW-1:0]    col_r, col_nxt;
  logic [RW-1:0]    row_r, row_nxt;

  logic             s1_valid_r;
  logic [PIX_W-1:0] s1_cur_r;
  logic [PIX_W-1:0] s1_left_r;
  logic [CW-1:0]    s1_col_r;
  logic [RW-1:0]    s1_row_r;

  logic             accept;
  logic [CMPW-1:0]  wlim;
  logic [RMPW-1:0]  hlim;
  logic [PIX_W+1:0] sum4;
  logic [PIX_W:0]   sum_v, sum_h;

  // A zero dimension acts as one, an oversize one as the maximum.
  always_comb begin
    if (image_width == '0) begin
      wlim = CMPW'(1);
    end else if (CMPW'(image_width) > CMPW'(MAX_WIDTH)) begin
      wlim = CMPW'(MAX_WIDTH);
    end else begin
      wlim = CMPW'(image_width);
    end
    if (image_height == '0) begin
      hlim = RMPW'(1);
    end else if (RMPW'(image_height) > RMPW'(MAX_HEIGHT)) begin
      hlim = RMPW'(MAX_HEIGHT);
    end else begin
      hlim = RMPW'(image_height);
    end
  end

  assign push     = s1_valid_r && !q_stat.full;
  assign in_stall = s1_valid_r && !push;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if ((CMPW'(col_r) + CMPW'(1)) >= wlim) begin
      col_nxt = '0;
      if ((RMPW'(row_r) + RMPW'(1)) >= hlim) begin
        row_nxt = '0;
      end else begin
        row_nxt = row_r + RW'(1);
      end
    end else begin
      col_nxt = col_r + CW'(1);
    end
  end

  // The read returns the entry from the row above, before this pixel overwrites it.
  always_ff @(posedge clk) begin
    if (accept) begin
      up_r             <= line_mem[col_r];
      line_mem[col_r]  <= in_pixel;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      col_r        <= '0;
      row_r        <= '0;
      left_r       <= '0;
      upper_left_r <= '0;
    end else begin
      if (accept) begin
        s1_valid_r <= 1'b1;
        col_r      <= col_nxt;
        row_r      <= row_nxt;
        left_r     <= in_pixel;
      end else if (push) begin
        s1_valid_r <= 1'b0;
      end
      if (push) begin
        upper_left_r <= up_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cur_r  <= in_pixel;
      s1_left_r <= left_r;
      s1_col_r  <= col_r;
      s1_row_r  <= row_r;
    end
  end

  assign sum4 = (PIX_W+2)'(upper_left_r) + (PIX_W+2)'(up_r) + (PIX_W+2)'(s1_left_r)
              + (PIX_W+2)'(s1_cur_r) + (PIX_W+2)'(2);
  assign sum_v = (PIX_W+1)'(up_r) + (PIX_W+1)'(s1_cur_r) + (PIX_W+1)'(1);
  assign sum_h = (PIX_W+1)'(s1_left_r) + (PIX_W+1)'(s1_cur_r) + (PIX_W+1)'(1);

  always_comb begin
    push_item.row2     = COORD_W'({s1_row_r, 1'b0});
    push_item.col2     = COORD_W'({s1_col_r, 1'b0});
    push_item.diag     = sum4[PIX_W+1:2];
    push_item.vert     = sum_v[PIX_W:1];
    push_item.horiz    = sum_h[PIX_W:1];
    push_item.copy     = s1_cur_r;
    push_item.has_up   = (s1_row_r != '0);
    push_item.has_left = (s1_col_r != '0);
  end

endmodule

// ----- rtl/core/izi_queue.sv -----
// Short queue of classified items between the front and back parts.
module izi_queue import izi_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  izi_item_t  push_item,
  input  logic       pop,
  output izi_item_t  head,
  output izi_qstat_t q_stat
);

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int NW = $clog2(QUEUE_DEPTH + 1);

  izi_item_t       entries [QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [NW-1:0]   count_r;

  assign q_stat.full  = (count_r == NW'(QUEUE_DEPTH));
  assign q_stat.empty = (count_r == '0);
  assign head         = entries[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + NW'(1);
      end else if (pop && !push) begin
        count_r <= count_r - NW'(1);
      end
    end
  end

endmodule

// ----- rtl/core/izi_back.sv -----
// Back part: steps through the results of the head item and drives the output register.
module izi_back import izi_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  izi_item_t          head,
  input  izi_qstat_t         q_stat,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [COORD_W-1:0] out_row,
  output logic [COORD_W-1:0] out_col,
  output logic [PIX_W-1:0]   out_value,
  output logic               out_last
);

  logic [2:0]         done_r;
  logic [2:0]         pending;
  logic [1:0]         kind;
  logic               load;
  logic               out_valid_r;
  logic [COORD_W-1:0] row_r, col_r;
  logic [PIX_W-1:0]   value_r;
  logic               last_r;
  logic [COORD_W-1:0] row_sel, col_sel;
  logic [PIX_W-1:0]   value_sel;

  // Results already sent for the head item are masked off.
  assign pending = {head.has_left, head.has_up, head.has_up && head.has_left} & ~done_r;

  always_comb begin
    if (pending[KIND_DIAG]) begin
      kind = KIND_DIAG;
    end else if (pending[KIND_VERT]) begin
      kind = KIND_VERT;
    end else if (pending[KIND_HORIZ]) begin
      kind = KIND_HORIZ;
    end else begin
      kind = KIND_COPY;
    end
  end

  always_comb begin
    case (kind)
      KIND_DIAG: begin
        row_sel   = head.row2 - COORD_W'(1);
        col_sel   = head.col2 - COORD_W'(1);
        value_sel = head.diag;
      end
      KIND_VERT: begin
        row_sel   = head.row2 - COORD_W'(1);
        col_sel   = head.col2;
        value_sel = head.vert;
      end
      KIND_HORIZ: begin
        row_sel   = head.row2;
        col_sel   = head.col2 - COORD_W'(1);
        value_sel = head.horiz;
      end
      default: begin
        row_sel   = head.row2;
        col_sel   = head.col2;
        value_sel = head.copy;
      end
    endcase
  end

  assign load = !q_stat.empty && (!out_valid_r || !out_stall);
  assign pop  = load && (kind == KIND_COPY);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      done_r      <= '0;
    end else begin
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (pop) begin
        done_r <= '0;
      end else if (load) begin
        done_r[kind] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      row_r   <= row_sel;
      col_r   <= col_sel;
      value_r <= value_sel;
      last_r  <= (kind == KIND_COPY);
    end
  end

  assign out_valid = out_valid_r;
  assign out_row   = row_r;
  assign out_col   = col_r;
  assign out_value = value_r;
  assign out_last  = last_r;

endmodule

// ----- rtl/core/image_zoom_2x_interpolate.sv -----
// The first result of an item passes the stage-one registers, the queue entry and the output register.
// Throughput: one result per cycle at the output register while out_stall is low; an item gives
// one to four results, depending on how many of them exist (four inside the image).
// Reset (synchronous, rst_n low) clears the position counters, the left and upper-left pixels,
// the queue and output valid, and sets both dimensions to 1024; the line store is not initialised.
module image_zoom_2x_interpolate import izi_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [PIX_W-1:0]   in_pixel,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [COORD_W-1:0] out_row,
  output logic [COORD_W-1:0] out_col,
  output logic [PIX_W-1:0]   out_value,
  output logic               out_last
);

  logic [DIM_W-1:0] width_r, height_r;
  logic             cfg_write;
  logic             push, pop;
  izi_item_t        push_item, head;
  izi_qstat_t       q_stat;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= DIM_RESET;
      height_r <= DIM_RESET;
    end else if (cfg_write) begin
      if (paddr[2] == REG_IMAGE_WIDTH) begin
        width_r <= pwdata[DIM_W-1:0];
      end else begin
        height_r <= pwdata[DIM_W-1:0];
      end
    end
  end

  assign prdata = (paddr[2] == REG_IMAGE_HEIGHT) ? DATA_W'(height_r) : DATA_W'(width_r);

  izi_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_pixel     (in_pixel),
    .image_width  (width_r),
    .image_height (height_r),
    .q_stat       (q_stat),
    .push         (push),
    .push_item    (push_item)
  );

  izi_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .q_stat    (q_stat)
  );

  izi_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .q_stat    (q_stat),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_row   (out_row),
    .out_col   (out_col),
    .out_value (out_value),
    .out_last  (out_last)
  );

  // The copied original always sits at even coordinates, every mean at an odd one.
  a_last_even: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> !out_row[0] && !out_col[0])
    else $error("final result of an item not at even coordinates");

  a_mean_odd: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> out_row[0] || out_col[0])
    else $error("interpolated result at even coordinates");

  a_queue_state: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_stat.full && q_stat.empty) && !(pop && q_stat.empty) && !(push && q_stat.full))
    else $error("queue pushed when full or popped when empty");

endmodule
